// ----- rtl/core/lcab_pkg.sv -----
package lcab_pkg;

   // Tree geometry
   localparam int NODE_W  = 16;
   localparam int NODES   = 2 ** NODE_W;
   localparam int LEVELS  = 17;
   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DEPTH_W = 17;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
   localparam int ANC_DEPTH = NODES * LEVELS;
   localparam int ANC_AW    = $clog2(ANC_DEPTH);

   // Lift compare width: depth plus the largest step 2^(LEVELS-1), plus carry
   localparam int CMP_W = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

   // Item kinds
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Depth read address sources
   localparam logic [1:0] DSEL_A   = 2'd0;
   localparam logic [1:0] DSEL_B   = 2'd1;
   localparam logic [1:0] DSEL_ANC = 2'd2;

   // Ancestor read row sources
   localparam logic [1:0] NSEL_A   = 2'd0;
   localparam logic [1:0] NSEL_B   = 2'd1;
   localparam logic [1:0] NSEL_CUR = 2'd2;

   typedef struct packed {
      logic       load;
      logic [1:0] dep_sel;
      logic [1:0] anc_sel;
      logic       anc_lvl_zero;
      logic       add_root;
      logic       add_step;
      logic       cap_da;
      logic       swap_cap;
      logic       lvl_dec;
      logic       lvl_top;
      logic       lift_a;
      logic       cap_pa;
      logic       up_step;
      logic       res_a;
      logic       res_anc;
      logic       out_load;
   } lcab_cmd_type;

   typedef struct packed {
      logic func;
      logic a_zero;
      logic lvl_zero;
      logic add_last;
      logic lift_ok;
      logic ab_eq;
      logic out_free;
   } lcab_sts_type;

endpackage

// ----- rtl/core/lcab_dpath.sv -----
module lcab_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  lcab_pkg::lcab_cmd_type            cmd,
   output lcab_pkg::lcab_sts_type            sts,
   input  logic                              req_func,
   input  logic [lcab_pkg::NODE_W-1:0]       req_node_a,
   input  logic [lcab_pkg::NODE_W-1:0]       req_node_b,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lcab_pkg::NODE_W-1:0]       rsp_common_ancestor
);

   localparam int NW = lcab_pkg::NODE_W;
   localparam int DW = lcab_pkg::DEPTH_W;
   localparam int LW = lcab_pkg::LVL_W;
   localparam int AW = lcab_pkg::ANC_AW;
   localparam int CW = lcab_pkg::CMP_W;

   // Storage
   logic [DW-1:0] depth_mem [0:lcab_pkg::NODES-1];
   logic [NW-1:0] anc_mem   [0:lcab_pkg::ANC_DEPTH-1];

   logic [DW-1:0] dep_q_ff;
   logic          dep_z_ff;
   logic [NW-1:0] anc_q_ff;
   logic          anc_z_ff;

   logic          func_ff, func_in;
   logic [NW-1:0] a_ff, a_in;
   logic [NW-1:0] b_ff, b_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] pa_ff, pa_in;
   logic [NW-1:0] res_ff, res_in;
   logic [DW-1:0] da_ff, da_in;
   logic [DW-1:0] db_ff, db_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_data_ff, rsp_data_in;

   logic [DW-1:0] dq;
   logic [NW-1:0] aq;
   logic [NW-1:0] dep_raddr;
   logic [NW-1:0] anc_rnode;
   logic [LW-1:0] anc_rlvl;
   logic [AW-1:0] anc_raddr;
   logic          anc_we;
   logic [LW-1:0] anc_wlvl;
   logic [AW-1:0] anc_waddr;
   logic [NW-1:0] anc_wdata;
   logic [DW-1:0] dep_wdata;
   logic [CW-1:0] lift_need;

   // Node zero is the sentinel: it reads as zero at every level
   assign dq = dep_z_ff ? '0 : dep_q_ff;
   assign aq = anc_z_ff ? '0 : anc_q_ff;

   // Read address selection
   always_comb begin
      case (cmd.dep_sel)
         lcab_pkg::DSEL_B:   dep_raddr = b_ff;
         lcab_pkg::DSEL_ANC: dep_raddr = aq;
         default:            dep_raddr = a_ff;
      endcase
      case (cmd.anc_sel)
         lcab_pkg::NSEL_B:   anc_rnode = b_ff;
         lcab_pkg::NSEL_CUR: anc_rnode = cur_ff;
         default:            anc_rnode = a_ff;
      endcase
   end

   assign anc_rlvl  = cmd.anc_lvl_zero ? '0 : lvl_ff;
   assign anc_raddr = AW'(anc_rnode) * AW'(lcab_pkg::LEVELS) + AW'(anc_rlvl);

   // Row write: level zero on the first step, the next level afterwards
   assign anc_we    = cmd.add_root | cmd.add_step;
   assign anc_wlvl  = cmd.add_root ? '0 : lvl_ff + LW'(1);
   assign anc_waddr = AW'(a_ff) * AW'(lcab_pkg::LEVELS) + AW'(anc_wlvl);
   assign anc_wdata = cmd.add_root ? b_ff : aq;

   // Saturate depth at its maximum
   assign dep_wdata = (dq == lcab_pkg::DEPTH_MAX) ? dq : dq + DW'(1);

   // Depth memory
   always_ff @(posedge clock) begin
      if (cmd.add_root) begin
         depth_mem[a_ff] <= dep_wdata;
      end
      dep_q_ff <= depth_mem[dep_raddr];
      dep_z_ff <= (dep_raddr == '0);
   end

   // Ancestor memory
   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_q_ff <= anc_mem[anc_raddr];
      anc_z_ff <= (anc_rnode == '0);
   end

   // Working registers
   always_comb begin
      func_in = func_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cur_in  = cur_ff;
      pa_in   = pa_ff;
      res_in  = res_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      lvl_in  = lvl_ff;
      if (cmd.load) begin
         func_in = req_func;
         a_in    = req_node_a;
         b_in    = req_node_b;
      end
      if (cmd.add_root) begin
         cur_in = b_ff;
         lvl_in = '0;
      end
      if (cmd.add_step) begin
         cur_in = aq;
         lvl_in = lvl_ff + LW'(1);
      end
      if (cmd.cap_da) begin
         da_in = dq;
      end
      // Keep the deeper node in a
      if (cmd.swap_cap) begin
         if (da_ff < dq) begin
            a_in  = b_ff;
            b_in  = a_ff;
            da_in = dq;
            db_in = da_ff;
         end else begin
            db_in = dq;
         end
      end
      if (cmd.lvl_top || cmd.swap_cap) begin
         lvl_in = LW'(lcab_pkg::LEVELS - 1);
      end
      if (cmd.lvl_dec) begin
         lvl_in = lvl_ff - LW'(1);
      end
      if (cmd.lift_a) begin
         a_in = aq;
      end
      if (cmd.cap_pa) begin
         pa_in = aq;
      end
      if (cmd.up_step && (pa_ff != aq)) begin
         a_in = pa_ff;
         b_in = aq;
      end
      if (cmd.res_a) begin
         res_in = a_ff;
      end
      if (cmd.res_anc) begin
         res_in = aq;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      cur_ff  <= cur_in;
      pa_ff   <= pa_in;
      res_ff  <= res_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      lvl_ff  <= lvl_in;
   end

   // Output register: hold the item until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_common_ancestor = rsp_data_ff;

   // Status back to the controller
   assign lift_need = CW'(db_ff) + (CW'(1) << lvl_ff);

   assign sts.func     = func_ff;
   assign sts.a_zero   = (a_ff == '0);
   assign sts.lvl_zero = (lvl_ff == '0);
   assign sts.add_last = (int'(lvl_ff) + 2 >= lcab_pkg::LEVELS);
   assign sts.lift_ok  = (CW'(da_ff) >= lift_need);
   assign sts.ab_eq    = (a_ff == b_ff);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

// ----- rtl/core/lcab_ctrl.sv -----
module lcab_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lcab_pkg::lcab_sts_type sts,
   output lcab_pkg::lcab_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_ADD_DEP  = 4'd2;
   localparam logic [3:0] ST_ADD_RD   = 4'd3;
   localparam logic [3:0] ST_ADD_WR   = 4'd4;
   localparam logic [3:0] ST_Q_RDB    = 4'd5;
   localparam logic [3:0] ST_Q_SWAP   = 4'd6;
   localparam logic [3:0] ST_LIFT_CHK = 4'd7;
   localparam logic [3:0] ST_LIFT_ANC = 4'd8;
   localparam logic [3:0] ST_LIFT_DEP = 4'd9;
   localparam logic [3:0] ST_CMP      = 4'd10;
   localparam logic [3:0] ST_UP_RDA   = 4'd11;
   localparam logic [3:0] ST_UP_RDB   = 4'd12;
   localparam logic [3:0] ST_UP_CMP   = 4'd13;
   localparam logic [3:0] ST_FIN_RD   = 4'd14;
   localparam logic [3:0] ST_FIN_Q    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       out_st_ff, out_st_in;

   assign req_tready = (state_ff == ST_IDLE) && !out_st_ff;

   // Sequence the add and query steps
   always_comb begin
      state_in  = state_ff;
      out_st_in = out_st_ff;
      cmd       = '0;
      cmd.dep_sel = lcab_pkg::DSEL_A;
      cmd.anc_sel = lcab_pkg::NSEL_A;
      if (out_st_ff) begin
         // Wait for the output register to free up
         if (sts.out_free) begin
            cmd.out_load = 1'b1;
            out_st_in    = 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               if (sts.func == lcab_pkg::FUNC_QUERY) begin
                  cmd.dep_sel = lcab_pkg::DSEL_A;
                  state_in    = ST_Q_RDB;
               end else if (sts.a_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dep_sel = lcab_pkg::DSEL_B;
                  state_in    = ST_ADD_DEP;
               end
            end
            ST_ADD_DEP: begin
               cmd.add_root = 1'b1;
               state_in     = (lcab_pkg::LEVELS > 1) ? ST_ADD_RD : ST_IDLE;
            end
            ST_ADD_RD: begin
               cmd.anc_sel = lcab_pkg::NSEL_CUR;
               state_in    = ST_ADD_WR;
            end
            ST_ADD_WR: begin
               cmd.add_step = 1'b1;
               state_in     = sts.add_last ? ST_IDLE : ST_ADD_RD;
            end
            ST_Q_RDB: begin
               cmd.cap_da  = 1'b1;
               cmd.dep_sel = lcab_pkg::DSEL_B;
               state_in    = ST_Q_SWAP;
            end
            ST_Q_SWAP: begin
               cmd.swap_cap = 1'b1;
               state_in     = ST_LIFT_CHK;
            end
            ST_LIFT_CHK: begin
               if (sts.lift_ok) begin
                  cmd.anc_sel = lcab_pkg::NSEL_A;
                  state_in    = ST_LIFT_ANC;
               end else if (sts.lvl_zero) begin
                  state_in = ST_CMP;
               end else begin
                  cmd.lvl_dec = 1'b1;
               end
            end
            ST_LIFT_ANC: begin
               cmd.lift_a  = 1'b1;
               cmd.dep_sel = lcab_pkg::DSEL_ANC;
               state_in    = ST_LIFT_DEP;
            end
            ST_LIFT_DEP: begin
               cmd.cap_da = 1'b1;
               if (sts.lvl_zero) begin
                  state_in = ST_CMP;
               end else begin
                  cmd.lvl_dec = 1'b1;
                  state_in    = ST_LIFT_CHK;
               end
            end
            ST_CMP: begin
               if (sts.ab_eq) begin
                  cmd.res_a = 1'b1;
                  out_st_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.lvl_top = 1'b1;
                  state_in    = ST_UP_RDA;
               end
            end
            ST_UP_RDA: begin
               cmd.anc_sel = lcab_pkg::NSEL_A;
               state_in    = ST_UP_RDB;
            end
            ST_UP_RDB: begin
               cmd.cap_pa  = 1'b1;
               cmd.anc_sel = lcab_pkg::NSEL_B;
               state_in    = ST_UP_CMP;
            end
            ST_UP_CMP: begin
               cmd.up_step = 1'b1;
               if (sts.lvl_zero) begin
                  state_in = ST_FIN_RD;
               end else begin
                  cmd.lvl_dec = 1'b1;
                  state_in    = ST_UP_RDA;
               end
            end
            ST_FIN_RD: begin
               cmd.anc_sel      = lcab_pkg::NSEL_A;
               cmd.anc_lvl_zero = 1'b1;
               state_in         = ST_FIN_Q;
            end
            ST_FIN_Q: begin
               cmd.res_anc = 1'b1;
               out_st_in   = 1'b1;
               state_in    = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         out_st_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         out_st_ff <= out_st_in;
      end
   end

endmodule

// ----- rtl/core/lca_binary_lifting.sv -----
// Lowest common ancestor by binary lifting over a rooted tree.
// Input channel req_*: one item per handshake. req_tuser selects the kind:
// 0 adds node_a with parent node_b (0 marks a root), 1 asks for the lowest
// common ancestor of node_a and node_b. Parents must be added before their
// children. An add gives no result; a query gives one item on rsp_*.
// Items are worked one at a time; req_tready is high only while the block
// is idle. Both memories have one read port with registered data, and
// every lifting step waits on that read.
// An add writes the depth and the parent row, then reads and writes the
// ancestor rows level by level; an add of node 0 is dropped. A query
// reads both depths and lifts the deeper node to the depth of the other.
// When the lifted nodes do not match, it lifts both jointly and reads the
// final parent. All of these steps are paced by the serial memory reads.
// The result waits in an output register while rsp_tready is low; the
// next item is accepted meanwhile, but its result is held back until the
// register is free. Reset is synchronous; node 0 reads as the all-zero
// sentinel without any clearing pass, so the block is ready right after
// reset. Entries of nodes never added read as anything.
module lca_binary_lifting (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] node_a, [31:16] node_b
   input  logic        req_tuser,  // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] common_ancestor
);

   lcab_pkg::lcab_cmd_type cmd;
   lcab_pkg::lcab_sts_type sts;

   lcab_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lcab_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_tuser),
      .req_node_a          (req_tdata[15:0]),
      .req_node_b          (req_tdata[31:16]),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_common_ancestor (rsp_tdata)
   );

endmodule
